[rtl/rgbhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types, constants and the divider step for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

    localparam int unsigned FRAC_BITS = 6;
    localparam int unsigned SCALE     = 1 << FRAC_BITS;
    localparam int unsigned PCT_MUL   = 100 * SCALE;
    localparam int unsigned HUE_MUL   = 60 * SCALE;
    localparam int unsigned HUE_LIMIT = 360 * SCALE;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned CH_MAX = (1 << CH_W) - 1;
    localparam int unsigned HUE_W  = 15;
    localparam int unsigned PCT_W  = 13;

    // quotient bits per division, numerator width, hue offset width
    localparam int unsigned Q_W     = $clog2(HUE_LIMIT);
    localparam int unsigned NUM_W   = CH_W + Q_W;
    localparam int unsigned HOFF_W  = $clog2(6 * CH_MAX);

    // brightness by reciprocal multiplication
    localparam int unsigned BRI_SHIFT = $clog2(CH_MAX * PCT_MUL) + CH_W;
    localparam longint unsigned BRI_RECIP =
        ((64'd1 << BRI_SHIFT) + CH_MAX - 1) / CH_MAX;
    localparam longint unsigned BRI_MUL   = PCT_MUL * BRI_RECIP;
    localparam int unsigned BRI_MUL_W = $clog2(BRI_MUL + 1);
    localparam int unsigned BRI_PROD_W = CH_W + BRI_MUL_W;

    // queues
    localparam int unsigned FQ_DEPTH = 4;
    localparam int unsigned FQ_AW    = $clog2(FQ_DEPTH);
    localparam int unsigned OQ_DEPTH = 2;
    localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness;
    } t_hsv_out;

    typedef struct packed {
        logic [NUM_W-1:0] sat_num;
        logic [CH_W-1:0]  sat_den;
        logic [NUM_W-1:0] hue_num;
        logic [CH_W-1:0]  hue_den;
        logic [PCT_W-1:0] brightness;
    } t_work;

    typedef struct packed {
        logic  valid;
        t_work work;
    } t_link;

    typedef struct packed {
        logic [CH_W-1:0] rem;
        logic [Q_W-1:0]  low;
        logic [Q_W-1:0]  quo;
    } t_div;

    typedef struct packed {
        t_div             sat;
        t_div             hue;
        logic [CH_W-1:0]  sat_den;
        logic [CH_W-1:0]  hue_den;
        logic [PCT_W-1:0] brightness;
    } t_stage;

    function automatic t_div div_load(logic [NUM_W-1:0] num);
        t_div d;
        d.rem = num[NUM_W-1 -: CH_W];
        d.low = num[Q_W-1:0];
        d.quo = '0;
        return d;
    endfunction

    // one restoring division step, one quotient bit
    function automatic t_div div_step(t_div d, logic [CH_W-1:0] den);
        logic [CH_W:0] sh;
        logic [CH_W:0] dn;
        logic          qb;
        t_div          r;
        sh    = {d.rem, d.low[Q_W-1]};
        dn    = {1'b0, den};
        qb    = (sh >= dn);
        r.low = {d.low[Q_W-2:0], 1'b0};
        r.rem = qb ? CH_W'(sh - dn) : sh[CH_W-1:0];
        r.quo = {d.quo[Q_W-2:0], qb};
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/rgbhsv_front.sv]
// ----------------------------------------------------------------------------
// rgbhsv_front
// Finds max, min and hue sector of each pixel, forms the division operands
// and brightness, and holds them in a short request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_front
    import rgbhsv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire t_pix_in i_pix,
    output t_link        o_link,
    input  wire logic    i_take
);

    logic [CH_W-1:0]       w_mx;
    logic [CH_W-1:0]       w_mn;
    logic [CH_W-1:0]       w_dl;
    logic signed [HOFF_W+1:0] w_off;
    logic [BRI_PROD_W-1:0] w_bri;
    t_work                 w_work;

    t_work              r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0]   r_wp;
    logic [FQ_AW-1:0]   r_rp;
    logic [FQ_AW:0]     r_cnt;
    logic [FQ_AW-1:0]   n_wp;
    logic [FQ_AW-1:0]   n_rp;
    logic [FQ_AW:0]     n_cnt;
    logic               w_wr;
    logic               w_rd;

    always_comb begin
        w_mx = i_pix.red;
        if (i_pix.green > w_mx) w_mx = i_pix.green;
        if (i_pix.blue > w_mx) w_mx = i_pix.blue;
        w_mn = i_pix.red;
        if (i_pix.green < w_mn) w_mn = i_pix.green;
        if (i_pix.blue < w_mn) w_mn = i_pix.blue;
        w_dl = w_mx - w_mn;

        // sector offset, red wins ties, then green
        if (i_pix.red >= i_pix.green && i_pix.red >= i_pix.blue) begin
            w_off = $signed({2'b0, HOFF_W'(i_pix.green)})
                  - $signed({2'b0, HOFF_W'(i_pix.blue)});
        end else if (i_pix.green >= i_pix.blue) begin
            w_off = $signed({2'b0, HOFF_W'({w_dl, 1'b0})})
                  + $signed({2'b0, HOFF_W'(i_pix.blue)})
                  - $signed({2'b0, HOFF_W'(i_pix.red)});
        end else begin
            w_off = $signed({2'b0, HOFF_W'({w_dl, 2'b0})})
                  + $signed({2'b0, HOFF_W'(i_pix.red)})
                  - $signed({2'b0, HOFF_W'(i_pix.green)});
        end
        if (w_off < 0) begin
            w_off = w_off + $signed({2'b0, HOFF_W'({w_dl, 2'b0})})
                  + $signed({2'b0, HOFF_W'({w_dl, 1'b0})});
        end

        w_bri = BRI_PROD_W'(w_mx) * BRI_PROD_W'(BRI_MUL);

        w_work.sat_num    = NUM_W'(w_dl) * NUM_W'(PCT_MUL);
        w_work.sat_den    = (w_mx == '0) ? CH_W'(1) : w_mx;
        // grey pixel gives zero hue
        w_work.hue_num    = (w_dl == '0) ? '0
                          : NUM_W'(w_off[HOFF_W-1:0]) * NUM_W'(HUE_MUL);
        w_work.hue_den    = (w_dl == '0) ? CH_W'(1) : w_dl;
        w_work.brightness = PCT_W'(w_bri >> BRI_SHIFT);
    end

    assign full = (r_cnt == (FQ_AW+1)'(FQ_DEPTH));
    assign w_wr = push && !full;
    assign w_rd = i_take && (r_cnt != '0);

    always_comb begin
        n_wp  = w_wr ? r_wp + FQ_AW'(1) : r_wp;
        n_rp  = w_rd ? r_rp + FQ_AW'(1) : r_rp;
        n_cnt = r_cnt + (FQ_AW+1)'(w_wr) - (FQ_AW+1)'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_work;
        end
    end

    assign o_link.valid = (r_cnt != '0);
    assign o_link.work  = r_mem[r_rp];

endmodule

`default_nettype wire

[rtl/rgbhsv_back.sv]
// ----------------------------------------------------------------------------
// rgbhsv_back
// Pipelined restoring dividers for hue and saturation, one quotient bit per
// stage, followed by the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_back
    import rgbhsv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_link i_link,
    output logic       o_take,
    output logic       empty,
    input  wire logic  pop,
    output t_hsv_out   o_hsv
);

    t_stage           r_stg [Q_W];
    t_stage           n_stg [Q_W];
    logic [Q_W-1:0]   r_vld;
    t_stage           w_first;
    t_hsv_out         w_res;
    logic             w_en;

    t_hsv_out         r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp;
    logic [OQ_AW-1:0] r_rp;
    logic [OQ_AW:0]   r_cnt;
    logic             w_wr;
    logic             w_rd;

    // pipeline moves while the result queue has room
    assign w_en   = (r_cnt != (OQ_AW+1)'(OQ_DEPTH));
    assign o_take = w_en && i_link.valid;

    always_comb begin
        w_first.sat        = div_load(i_link.work.sat_num);
        w_first.hue        = div_load(i_link.work.hue_num);
        w_first.sat_den    = i_link.work.sat_den;
        w_first.hue_den    = i_link.work.hue_den;
        w_first.brightness = i_link.work.brightness;
        for (int s = 0; s < Q_W; s++) begin
            n_stg[s] = (s == 0) ? w_first : r_stg[(s == 0) ? 0 : s-1];
            n_stg[s].sat = div_step(n_stg[s].sat, n_stg[s].sat_den);
            n_stg[s].hue = div_step(n_stg[s].hue, n_stg[s].hue_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Q_W-2:0], i_link.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stg <= n_stg;
        end
    end

    always_comb begin
        w_res.hue        = HUE_W'(r_stg[Q_W-1].hue.quo);
        w_res.saturation = PCT_W'(r_stg[Q_W-1].sat.quo);
        w_res.brightness = r_stg[Q_W-1].brightness;
    end

    assign w_wr  = w_en && r_vld[Q_W-1];
    assign empty = (r_cnt == '0);
    assign w_rd  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + OQ_AW'(1);
            if (w_rd) r_rp <= r_rp + OQ_AW'(1);
            r_cnt <= r_cnt + (OQ_AW+1)'(w_wr) - (OQ_AW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_oq[r_wp] <= w_res;
        end
    end

    assign o_hsv = r_oq[r_rp];

endmodule

`default_nettype wire

[rtl/rgb_to_hsv_converter_top.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// 8-bit RGB pixel in, hue, saturation and brightness out as fixed point.
//
//   channel   handshake         payload
//   pixel in  push / full       i_pix  (red, green, blue)
//   hsv out   pop / empty       o_hsv  (hue, saturation, brightness)
//
// one pixel per clock sustained while results are popped; a request passes
// the front queue, the 15 stage divider pipeline and the result queue in order.
// synchronous reset clears queue pointers and pipeline valid bits only.
// a full result queue freezes the divider pipeline; the 4 entry front queue
// keeps taking requests until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_top
    import rgbhsv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire t_pix_in i_pix,
    output logic         empty,
    input  wire logic    pop,
    output t_hsv_out     o_hsv
);

    t_link w_link;
    logic  w_take;

    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_pix   (i_pix),
        .o_link  (w_link),
        .i_take  (w_take)
    );

    rgbhsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (w_link),
        .o_take  (w_take),
        .empty   (empty),
        .pop     (pop),
        .o_hsv   (o_hsv)
    );

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_link.valid)
        else $error("divider took from an empty queue");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link.valid |-> (w_link.work.sat_den != '0 && w_link.work.hue_den != '0))
        else $error("zero divisor queued");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (32'(o_hsv.hue) < HUE_LIMIT))
        else $error("hue out of range");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (32'(o_hsv.saturation) <= PCT_MUL
                 && 32'(o_hsv.brightness) <= PCT_MUL))
        else $error("percentage out of range");

endmodule

`default_nettype wire

[test/rgb_to_hsv_converter_checker.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_checker
// Watches both queue ports of the converter. Every accepted pixel gets its
// HSV value worked out here and is queued in order. Every popped result is
// compared field by field against the oldest entry in that queue. The
// failure count, the backlog and the number of compared results go back to
// the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_checker
    import rgbhsv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire logic     i_full,
    input  wire t_pix_in  i_pix,
    input  wire logic     i_empty,
    input  wire logic     i_pop,
    input  wire t_hsv_out i_hsv,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PCT_FULL    = 100 * (1 << FRAC_BITS);
    localparam longint HUE_FULL    = 60 * (1 << FRAC_BITS);
    localparam int     MAX_REPORTS = 40;

    t_hsv_out expected_hsv_q[$];
    int       fail_total    = 0;
    int       checked_total = 0;

    function automatic t_hsv_out predict_hsv(t_pix_in p);
        longint   r;
        longint   g;
        longint   b;
        longint   mx;
        longint   mn;
        longint   delta;
        longint   sector_num;
        longint   hue_full;
        longint   sat_full;
        longint   bri_full;
        t_hsv_out res;
        r  = p.red;
        g  = p.green;
        b  = p.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta    = mx - mn;
        bri_full = mx * PCT_FULL / CH_MAX;
        sat_full = (mx == 0) ? 0 : delta * PCT_FULL / mx;
        hue_full = 0;
        if (delta != 0) begin
            // red wins a tie for the maximum, then green
            if (mx == r)
                sector_num = g - b;
            else if (mx == g)
                sector_num = 2 * delta + (b - r);
            else
                sector_num = 4 * delta + (r - g);
            if (sector_num < 0)
                sector_num += 6 * delta;
            hue_full = sector_num * HUE_FULL / delta;
        end
        res.hue        = HUE_W'(hue_full);
        res.saturation = PCT_W'(sat_full);
        res.brightness = PCT_W'(bri_full);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hsv_out want;
        if (i_rst_n) begin
            if (i_pop && !i_empty) begin
                if (expected_hsv_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= MAX_REPORTS)
                        $display("%0t unexpected result: expected none, actual %h",
                                 $time, i_hsv);
                end else begin
                    want = expected_hsv_q.pop_front();
                    checked_total++;
                    if (i_hsv !== want) begin
                        fail_total++;
                        if (fail_total <= MAX_REPORTS) begin
                            if (i_hsv.hue !== want.hue)
                                $display("%0t hue: expected %0d, actual %0d",
                                         $time, want.hue, i_hsv.hue);
                            if (i_hsv.saturation !== want.saturation)
                                $display("%0t saturation: expected %0d, actual %0d",
                                         $time, want.saturation, i_hsv.saturation);
                            if (i_hsv.brightness !== want.brightness)
                                $display("%0t brightness: expected %0d, actual %0d",
                                         $time, want.brightness, i_hsv.brightness);
                        end
                    end
                end
            end
            if (i_push && !i_full)
                expected_hsv_q.push_back(predict_hsv(i_pix));
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_hsv_q.size();
        o_checked    <= checked_total;
    end

endmodule

`default_nettype wire

[test/rgb_to_hsv_converter_top_tb.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top_tb
// Drives pixels into the converter and pops results under three idle
// profiles: mostly stalled output, mostly idle input, and no idling. A short
// directed set comes first, then random pixels biased towards greys, tied
// channels and extreme levels. One long output hold fills the block. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbhsv_pkg::*;

    localparam int RANDOM_PER_PHASE = 630;
    localparam int FLOOD_ITEMS      = 40;
    localparam int LONG_HOLD        = 150;
    localparam int DRAIN_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT   = 1000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        pop     = 1'b0;
    t_pix_in     i_pix   = '0;
    logic        full;
    logic        empty;
    t_hsv_out    o_hsv;
    int          fail_count;
    int          pending;
    int          checked;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned hold_req_cnt  = 0;
    int          pixels_sent   = 0;
    int          quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    rgb_to_hsv_converter_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_pix   (i_pix),
        .empty   (empty),
        .pop     (pop),
        .o_hsv   (o_hsv)
    );

    rgb_to_hsv_converter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_pix        (i_pix),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_hsv        (o_hsv),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    function automatic logic [CH_W-1:0] pick_extreme();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            3: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pix_in random_pixel();
        t_pix_in         p;
        logic [CH_W-1:0] lvl;
        p   = t_pix_in'(24'($urandom));
        lvl = 8'($urandom);
        case ($urandom_range(9))
            5: p = '{lvl, lvl, lvl};
            6: begin
                case ($urandom_range(2))
                    0: p.green = p.red;
                    1: p.blue  = p.green;
                    default: p.blue = p.red;
                endcase
            end
            7, 8: begin
                p.red   = pick_extreme();
                p.green = pick_extreme();
                p.blue  = pick_extreme();
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(input t_pix_in p);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_pix <= p;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic wait_all_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // receiver side: random pops, plus the long hold when requested
    initial begin
        int unsigned hold_seen = 0;
        int          hold_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req_cnt != hold_seen) begin
                hold_seen = hold_req_cnt;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [23:0] directed_set [] = '{
            24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
            24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
            24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF00FE,
            24'h010000, 24'h000001, 24'h000100, 24'hFFFE00,
            24'hFEFF00, 24'h00FF01, 24'h8000FF, 24'hFF0100,
            24'h0A141E, 24'hC86432, 24'h010100, 24'h7F80FF
        };
        int idle_send [3] = '{15, 86, 0};
        int idle_recv [3] = '{86, 15, 0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = idle_send[ph];
            recv_idle_pct = idle_recv[ph];
            if (ph == 0)
                foreach (directed_set[i])
                    send_pixel(t_pix_in'(directed_set[i]));
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // fill the block against a held output
                if (ph == 2 && n == RANDOM_PER_PHASE / 2) begin
                    hold_req_cnt <= hold_req_cnt + 1;
                    repeat (FLOOD_ITEMS)
                        send_pixel(random_pixel());
                end
                send_pixel(random_pixel());
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d pixels: black, grey, tied and wrapping hues, extreme levels",
                 pixels_sent);
        $display("three idle profiles and one full-block hold, %0d results compared",
                 checked);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_front.sv
rtl/rgbhsv_back.sv
rtl/rgb_to_hsv_converter_top.sv
test/rgb_to_hsv_converter_checker.sv
test/rgb_to_hsv_converter_top_tb.sv
